>>> hdl/sbog_pkg.sv
// Shared types and constants for the strided binary offset generator.
// No dependencies; used by the top level and its assertion checker.
package sbog_pkg;

  localparam int unsigned MaxDimsDefault = 4;
  localparam int unsigned IdxW           = 32;
  localparam int unsigned SizeW          = 16;
  localparam int unsigned SumW           = 34;
  localparam int unsigned OffW           = 32;
  localparam int unsigned CfgW           = 64;
  localparam int unsigned CfgIdxW        = 3;
  localparam int unsigned TensorCnt      = 3;
  localparam int unsigned ElemShift      = 2;
  localparam int unsigned BitsPerStep    = 4;
  localparam int unsigned DivSteps       = IdxW / BitsPerStep;

  typedef enum logic [CfgIdxW-1:0] {
    RegDimCount      = 3'd0,
    RegDimSizes      = 3'd1,
    RegFirstStrides  = 3'd2,
    RegSecondStrides = 3'd3,
    RegDestStrides   = 3'd4,
    RegElementTotal  = 3'd5
  } cfg_reg_e;

  // One pipeline slot.
  typedef struct packed {
    logic                             vld;
    logic                             rng;
    logic [IdxW-1:0]                  num;
    logic [SizeW-1:0]                 rem;
    logic [TensorCnt-1:0][SumW-1:0]   sum;
    logic [TensorCnt-1:0][OffW-1:0]   prd;
  } stage_t;

  // Result word: three offsets plus the in-range flag.
  typedef struct packed {
    logic                             rng;
    logic [TensorCnt-1:0][OffW-1:0]   off;
  } result_t;

endpackage

>>> hdl/strided_binary_offset_generator.sv
// Strided binary offset generator: top level with the division and MAC pipeline.
// Depends on sbog_pkg.
//
//  Channel   | Dir | Handshake           | Payload
//  s_axis    | in  | tvalid/tready       | tdata[31:0] linear_index
//  m_axis    | out | tvalid/tready       | tdata offsets, tuser in_range
//  cfg       | in  | cfg_we_i, no wait   | cfg_idx_i register, cfg_data_i value
//
// One request enters per cycle while the skid register is empty. Each request passes,
// per dimension, through DivSteps compare-subtract stages (four quotient bits each) and
// one multiply stage, and the output register follows the last of them. Reset clears
// all valid bits and loads the configuration reset values. When the output stalls,
// a one-entry skid register keeps accepting; once it fills the pipeline freezes.
module strided_binary_offset_generator #(
  parameter int unsigned MAX_DIMS = sbog_pkg::MaxDimsDefault
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        s_axis_tvalid_i,
  output logic                        s_axis_tready_o,
  input  logic [sbog_pkg::IdxW-1:0]   s_axis_tdata_i,   // [31:0] linear_index
  output logic                        m_axis_tvalid_o,
  input  logic                        m_axis_tready_i,
  // [31:0] first_offset, [63:32] second_offset, [95:64] dest_offset
  output logic [95:0]                 m_axis_tdata_o,
  output logic [0:0]                  m_axis_tuser_o,   // [0] in_range
  input  logic                        cfg_we_i,
  input  logic [sbog_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  logic [sbog_pkg::CfgW-1:0]   cfg_data_i
);
  import sbog_pkg::*;

  localparam int unsigned StagesPerDim = DivSteps + 1;
  localparam int unsigned NumStages    = MAX_DIMS * StagesPerDim;

  // Configuration registers.
  logic [2:0]      dim_count_q;
  logic [CfgW-1:0] dim_sizes_q;
  logic [CfgW-1:0] strides_q [TensorCnt];
  logic [IdxW-1:0] element_total_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dim_count_q     <= 3'd1;
      dim_sizes_q     <= CfgW'(1);
      strides_q[0]    <= '0;
      strides_q[1]    <= '0;
      strides_q[2]    <= '0;
      element_total_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        RegDimCount:      dim_count_q     <= cfg_data_i[2:0];
        RegDimSizes:      dim_sizes_q     <= cfg_data_i;
        RegFirstStrides:  strides_q[0]    <= cfg_data_i;
        RegSecondStrides: strides_q[1]    <= cfg_data_i;
        RegDestStrides:   strides_q[2]    <= cfg_data_i;
        RegElementTotal:  element_total_q <= cfg_data_i[IdxW-1:0];
        default: ;
      endcase
    end
  end

  // The whole pipeline advances together unless the skid register is occupied.
  logic    adv;
  logic    skid_vld_q;
  result_t skid_q;
  logic    out_vld_q;
  result_t out_q;

  assign adv             = ~skid_vld_q;
  assign s_axis_tready_o = adv;

  stage_t st_q [NumStages];
  stage_t st_d [NumStages];
  stage_t entry;

  always_comb begin
    entry     = '0;
    entry.vld = s_axis_tvalid_i & adv;
    entry.num = s_axis_tdata_i;
    entry.rng = s_axis_tdata_i < element_total_q;
  end

  for (genvar i = 0; i < NumStages; i++) begin : g_stage
    localparam int unsigned Pos  = i / StagesPerDim;
    localparam int unsigned Step = i % StagesPerDim;
    localparam int unsigned Dim  = MAX_DIMS - 1 - Pos;

    stage_t           src;
    logic [SizeW-1:0] size_raw;
    logic [SizeW-1:0] size;

    assign src      = (i == 0) ? entry : st_q[(i == 0) ? 0 : i - 1];
    assign size_raw = dim_sizes_q[SizeW*Dim +: SizeW];
    // Unused dimensions and zero sizes divide by one: coordinate zero.
    assign size     = ((dim_count_q > 3'(Dim)) && (size_raw != '0)) ? size_raw
                                                                   : SizeW'(1);

    if (Step < DivSteps) begin : g_div
      // Restoring division, four quotient bits per stage.
      always_comb begin
        logic [SizeW:0]   t;
        logic [SizeW-1:0] r;
        logic [IdxW-1:0]  n;
        r = src.rem;
        n = src.num;
        for (int b = 0; b < BitsPerStep; b++) begin
          t = {r, n[IdxW-1]};
          n = {n[IdxW-2:0], 1'b0};
          if (t >= {1'b0, size}) begin
            t    = t - {1'b0, size};
            n[0] = 1'b1;
          end
          r = t[SizeW-1:0];
        end
        st_d[i]     = src;
        st_d[i].num = n;
        st_d[i].rem = r;
      end
    end else begin : g_mul
      // Fold the previous products into the sums and form this dimension's.
      always_comb begin
        st_d[i] = src;
        for (int k = 0; k < TensorCnt; k++) begin
          st_d[i].sum[k] = src.sum[k] + SumW'(src.prd[k]);
          st_d[i].prd[k] = OffW'(src.rem) * OffW'(strides_q[k][SizeW*Dim +: SizeW]);
        end
        st_d[i].rem = '0;
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        st_q[i] <= '0;
      end else if (adv) begin
        st_q[i] <= st_d[i];
      end
    end
  end

  // Last accumulate, scale bytes to elements, and zero out-of-range results.
  stage_t  last;
  result_t res;
  logic    res_vld;

  assign last    = st_q[NumStages-1];
  assign res_vld = last.vld;

  always_comb begin
    logic [SumW-1:0] total;
    res     = '0;
    res.rng = last.rng;
    for (int k = 0; k < TensorCnt; k++) begin
      total      = last.sum[k] + SumW'(last.prd[k]);
      res.off[k] = last.rng ? OffW'(total >> ElemShift) : '0;
    end
  end

  // Output register with a skid entry behind it.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q  <= 1'b0;
      skid_vld_q <= 1'b0;
    end else if (!out_vld_q || m_axis_tready_i) begin
      if (skid_vld_q) begin
        out_vld_q  <= 1'b1;
        skid_vld_q <= 1'b0;
      end else begin
        out_vld_q <= adv & res_vld;
      end
    end else if (adv && res_vld) begin
      skid_vld_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!out_vld_q || m_axis_tready_i) begin
      out_q <= skid_vld_q ? skid_q : res;
    end else if (adv && res_vld) begin
      skid_q <= res;
    end
  end

  assign m_axis_tvalid_o = out_vld_q;
  assign m_axis_tdata_o  = {out_q.off[2], out_q.off[1], out_q.off[0]};
  assign m_axis_tuser_o  = out_q.rng;

endmodule

>>> hdl/sbog_checker.sv
// Port-level checker for the strided binary offset generator, bound to the top level.
// Depends on sbog_pkg and strided_binary_offset_generator.
module sbog_checker (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         s_axis_tvalid_i,
  input logic                         s_axis_tready_o,
  input logic [sbog_pkg::IdxW-1:0]    s_axis_tdata_i,
  input logic                         m_axis_tvalid_o,
  input logic                         m_axis_tready_i,
  input logic [95:0]                  m_axis_tdata_o,
  input logic [0:0]                   m_axis_tuser_o
);

  // Input back-pressure only appears while a result waits at the output.
  a_stall_needs_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready_o |-> m_axis_tvalid_o)
    else $error("input stalled with no pending result");

  // Out-of-range requests carry zero offsets.
  a_out_of_range_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && !m_axis_tuser_o[0]) |-> (m_axis_tdata_o == '0))
    else $error("out-of-range result has nonzero offsets");

  // A stalled result holds.
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && !m_axis_tready_i) |=>
      (m_axis_tvalid_o && $stable(m_axis_tdata_o) && $stable(m_axis_tuser_o)))
    else $error("stalled result changed");

  // Back-pressure only rises after a result went untaken.
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(s_axis_tready_o) |-> ($past(m_axis_tvalid_o) && !$past(m_axis_tready_i)))
    else $error("input stalled without output back-pressure");

  // An offered request carries a known index.
  a_known_request: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid_i |-> !$isunknown(s_axis_tdata_i))
    else $error("request index has unknown bits");

endmodule

bind strided_binary_offset_generator sbog_checker u_sbog_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .s_axis_tvalid_i (s_axis_tvalid_i),
  .s_axis_tready_o (s_axis_tready_o),
  .s_axis_tdata_i  (s_axis_tdata_i),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o),
  .m_axis_tuser_o  (m_axis_tuser_o)
);
